@@ rtl/kai_pkg.sv @@
// ----------------------------------------------------------------------------
// kai_pkg
// Shared widths, codes, divider request types and helpers for the keyframe
// angle interpolator.
// ----------------------------------------------------------------------------
package kai_pkg;

  // Field widths
  localparam int STEP_FRAC_BITS = 16;
  localparam int STEP_W         = STEP_FRAC_BITS + 1;   // 0..ONE inclusive
  localparam int QSTEP_W        = STEP_FRAC_BITS + 2;   // signed query step
  localparam int ANG_W          = 17;
  localparam int OUT_W          = 18;
  localparam int DELTA_W        = ANG_W + 1;

  // Divider geometry: dividend is |delta * num| + den / 2
  localparam int DIV_DVD_W = 34;
  localparam int DIV_DVS_W = STEP_W;
  localparam int DIV_QUO_W = 18;
  localparam int PROD_W    = DIV_DVD_W + 1;

  // Constants
  localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1 << STEP_FRAC_BITS);
  localparam int ANG_MIN_I  = -46080;
  localparam int ANG_MAX_I  = 46079;
  localparam int FULL_TURN  = 23040;
  localparam int HALF_TURN  = 11520;

  // Function codes
  localparam logic [1:0] FN_CLEAR  = 2'd0;
  localparam logic [1:0] FN_APPEND = 2'd1;
  localparam logic [1:0] FN_QUERY  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_ORDER = 2'd3;

  typedef struct packed {
    logic                 start;
    logic [DIV_DVD_W-1:0] dividend;
    logic [DIV_DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_QUO_W-1:0] quotient;
  } div_rsp_t;

  // Clamp an angle to the legal range
  function automatic logic signed [ANG_W-1:0] sat_angle(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] lo;
    logic signed [ANG_W-1:0] hi;
    lo = ANG_W'(ANG_MIN_I);
    hi = ANG_W'(ANG_MAX_I);
    if (a < lo) begin
      return lo;
    end else if (a > hi) begin
      return hi;
    end
    return a;
  endfunction

endpackage

@@ rtl/keyframe_angle_interpolator_top.sv @@
// ----------------------------------------------------------------------------
// keyframe_angle_interpolator_top
// Keyframe table with shortest-arc linear interpolation of angles.
// ----------------------------------------------------------------------------
// Clear, append, unused codes and a query on an empty table: result one cycle
// after the request, busy stays low, so one such request per cycle.
// Query with n keys: busy stays high until the result, so no new request is taken
// before it; the key scan reads all n keys and the divider takes 18 steps, then done.
// A query at step one or later skips the divider and returns the last key's angle.
// Reset (rst_ni low, asynchronous) empties the table and sets default_angle 0.
module keyframe_angle_interpolator_top #(
  parameter int MAX_KEYS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          func_i,
  input  logic [kai_pkg::STEP_W-1:0]          key_step_i,
  input  logic signed [kai_pkg::ANG_W-1:0]    key_angle_i,
  input  logic signed [kai_pkg::QSTEP_W-1:0]  query_step_i,
  input  logic                                cfg_we_i,
  input  logic signed [kai_pkg::ANG_W-1:0]    cfg_wdata_i,
  output logic                                strobe,
  output logic signed [kai_pkg::OUT_W-1:0]    angle_out_o,
  output logic [1:0]                          status_o
);
  import kai_pkg::*;

  localparam int AW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_FILL, S_DIFF, S_MUL, S_ROUND, S_DIV
  } state_e;

  state_e                   state_q, state_d;
  logic [CW-1:0]            count_q, count_d;
  logic [STEP_W-1:0]        last_step_q, last_step_d;
  logic signed [ANG_W-1:0]  dflt_q, dflt_d;
  logic [CW-1:0]            idx_q, idx_d;
  logic                     pend_q, pend_d;
  logic [STEP_W-1:0]        qs_q, qs_d;
  logic [STEP_W-1:0]        sb_q, sb_d;
  logic [STEP_W-1:0]        sa_q, sa_d;
  logic signed [ANG_W-1:0]  vb_q, vb_d;
  logic signed [ANG_W-1:0]  va_q, va_d;
  logic signed [ANG_W-1:0]  last_ang_q, last_ang_d;
  logic                     found_q, found_d;
  logic signed [DELTA_W-1:0] delta_q, delta_d;
  logic [STEP_W-1:0]        num_q, num_d;
  logic [STEP_W-1:0]        den_q, den_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic                     valid_q, valid_d;
  logic signed [OUT_W-1:0]  angle_q, angle_d;
  logic [1:0]               status_q, status_d;

  logic                     accept;
  logic [STEP_W-1:0]        ks_sat;
  logic signed [ANG_W-1:0]  ka_sat;
  logic [STEP_W-1:0]        qs_clamp;
  logic                     tbl_full;
  logic                     order_bad;
  logic                     mem_we;
  logic [STEP_W-1:0]        rd_step;
  logic signed [ANG_W-1:0]  rd_ang;
  logic signed [DELTA_W-1:0] diff;
  logic [DELTA_W-1:0]       diff_mag;
  logic signed [PROD_W-1:0] prod_neg;
  logic [DIV_DVD_W-1:0]     prod_mag;
  logic signed [DIV_QUO_W:0] q_signed;
  logic signed [OUT_W:0]    interp_sum;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  assign accept = start && (state_q == S_IDLE);

  // Saturate the incoming key and clamp the query step
  assign ks_sat    = (key_step_i > STEP_ONE) ? STEP_ONE : key_step_i;
  assign ka_sat    = sat_angle(key_angle_i);
  assign tbl_full  = (count_q == CW'(MAX_KEYS));
  assign order_bad = (count_q != '0) && (ks_sat < last_step_q);
  assign mem_we    = accept && (func_i == FN_APPEND) && !tbl_full && !order_bad;

  always_comb begin
    if (query_step_i < 0) begin
      qs_clamp = '0;
    end else if (query_step_i > $signed({1'b0, STEP_ONE})) begin
      qs_clamp = STEP_ONE;
    end else begin
      qs_clamp = query_step_i[STEP_W-1:0];
    end
  end

  kai_key_mem #(
    .DEPTH (MAX_KEYS),
    .AW    (AW)
  ) u_key_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[AW-1:0]),
    .wstep_i (ks_sat),
    .wang_i  (ka_sat),
    .raddr_i (idx_q[AW-1:0]),
    .rstep_o (rd_step),
    .rang_o  (rd_ang)
  );

  // Raw key difference and its magnitude for the shortest-arc choice
  assign diff     = {va_q[ANG_W-1], va_q} - {vb_q[ANG_W-1], vb_q};
  assign diff_mag = diff[DELTA_W-1] ? DELTA_W'(-diff) : DELTA_W'(diff);

  // Magnitude of the product plus half the spacing for rounding
  assign prod_neg = -prod_q;
  assign prod_mag = prod_q[PROD_W-1] ? prod_neg[DIV_DVD_W-1:0] : prod_q[DIV_DVD_W-1:0];

  assign div_req.start    = (state_q == S_ROUND);
  assign div_req.dividend = prod_mag + DIV_DVD_W'(den_q >> 1);
  assign div_req.divisor  = den_q;

  kai_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Apply the sign and add to the earlier angle
  assign q_signed   = prod_q[PROD_W-1] ? -$signed({1'b0, div_rsp.quotient})
                                       :  $signed({1'b0, div_rsp.quotient});
  assign interp_sum = (OUT_W + 1)'(vb_q) + (OUT_W + 1)'(q_signed);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    last_step_d = last_step_q;
    dflt_d      = dflt_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    qs_d        = qs_q;
    sb_d        = sb_q;
    sa_d        = sa_q;
    vb_d        = vb_q;
    va_d        = va_q;
    last_ang_d  = last_ang_q;
    found_d     = found_q;
    delta_d     = delta_q;
    num_d       = num_q;
    den_d       = den_q;
    prod_d      = prod_q;
    valid_d     = 1'b0;
    angle_d     = angle_q;
    status_d    = status_q;

    if (cfg_we_i) begin
      dflt_d = sat_angle(cfg_wdata_i);
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          valid_d  = 1'b1;
          angle_d  = '0;
          status_d = ST_OK;
          case (func_i)
            FN_CLEAR: begin
              count_d = '0;
            end
            FN_APPEND: begin
              if (tbl_full) begin
                status_d = ST_FULL;
              end else if (order_bad) begin
                status_d = ST_ORDER;
              end else begin
                count_d     = count_q + 1'b1;
                last_step_d = ks_sat;
              end
            end
            FN_QUERY: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                valid_d = 1'b0;
                qs_d    = qs_clamp;
                sb_d    = '0;
                vb_d    = dflt_q;
                found_d = 1'b0;
                idx_d   = '0;
                pend_d  = 1'b0;
                state_d = S_SCAN;
              end
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        // Take the key read last cycle
        if (pend_q) begin
          last_ang_d = rd_ang;
          if (rd_step <= qs_q) begin
            sb_d = rd_step;
            vb_d = rd_ang;
          end else if (!found_q) begin
            sa_d    = rd_step;
            va_d    = rd_ang;
            found_d = 1'b1;
          end
        end
        // Advance the read address
        if (idx_q != count_q) begin
          idx_d  = idx_q + 1'b1;
          pend_d = 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = S_FILL;
        end
      end
      S_FILL: begin
        if (qs_q == STEP_ONE) begin
          valid_d  = 1'b1;
          angle_d  = OUT_W'(last_ang_q);
          status_d = ST_OK;
          state_d  = S_IDLE;
        end else begin
          if (!found_q) begin
            sa_d = STEP_ONE;
            va_d = last_ang_q;
          end
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        if (diff_mag <= DELTA_W'(HALF_TURN)) begin
          delta_d = diff;
        end else if (diff[DELTA_W-1]) begin
          delta_d = diff + DELTA_W'(FULL_TURN);
        end else begin
          delta_d = diff - DELTA_W'(FULL_TURN);
        end
        num_d   = qs_q - sb_q;
        den_d   = sa_q - sb_q;
        state_d = S_MUL;
      end
      S_MUL: begin
        prod_d  = PROD_W'(delta_q) * PROD_W'($signed({1'b0, num_q}));
        state_d = S_ROUND;
      end
      S_ROUND: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          valid_d  = 1'b1;
          angle_d  = interp_sum[OUT_W-1:0];
          status_d = ST_OK;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      last_step_q <= '0;
      dflt_q      <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      qs_q        <= '0;
      sb_q        <= '0;
      sa_q        <= '0;
      vb_q        <= '0;
      va_q        <= '0;
      last_ang_q  <= '0;
      found_q     <= 1'b0;
      delta_q     <= '0;
      num_q       <= '0;
      den_q       <= '0;
      prod_q      <= '0;
      valid_q     <= 1'b0;
      angle_q     <= '0;
      status_q    <= ST_OK;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      last_step_q <= last_step_d;
      dflt_q      <= dflt_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      qs_q        <= qs_d;
      sb_q        <= sb_d;
      sa_q        <= sa_d;
      vb_q        <= vb_d;
      va_q        <= va_d;
      last_ang_q  <= last_ang_d;
      found_q     <= found_d;
      delta_q     <= delta_d;
      num_q       <= num_d;
      den_q       <= den_d;
      prod_q      <= prod_d;
      valid_q     <= valid_d;
      angle_q     <= angle_d;
      status_q    <= status_d;
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign strobe      = valid_q;
  assign angle_out_o = angle_q;
  assign status_o    = status_q;

`ifndef SYNTHESIS
  // A result never shows while a query is still running
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> !busy)
    else $error("result strobe while busy");

  // Key count stays within the table
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_KEYS))
    else $error("key count beyond table depth");

  // Divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV))
    else $error("divider done outside wait state");

  // A query on a filled table holds off the result and raises busy
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (func_i == FN_QUERY) && (count_q != '0)) |=> (busy && !strobe))
    else $error("query did not start");

  // Append to a full table reports full and leaves the count alone
  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (func_i == FN_APPEND) && tbl_full)
      |=> (strobe && (status_o == ST_FULL) && (count_q == $past(count_q))))
    else $error("append on full table not dropped");
`endif

endmodule

@@ rtl/kai_key_mem.sv @@
// ----------------------------------------------------------------------------
// kai_key_mem
// Keyframe storage: step and angle per entry, one write port and one
// registered read port.
// ----------------------------------------------------------------------------
module kai_key_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [AW-1:0]                      waddr_i,
  input  logic [kai_pkg::STEP_W-1:0]         wstep_i,
  input  logic signed [kai_pkg::ANG_W-1:0]   wang_i,
  input  logic [AW-1:0]                      raddr_i,
  output logic [kai_pkg::STEP_W-1:0]         rstep_o,
  output logic signed [kai_pkg::ANG_W-1:0]   rang_o
);
  import kai_pkg::*;

  logic [STEP_W-1:0]        step_mem [DEPTH];
  logic signed [ANG_W-1:0]  ang_mem  [DEPTH];

  // Write the appended key
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      step_mem[waddr_i] <= wstep_i;
      ang_mem[waddr_i]  <= wang_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    rstep_o <= step_mem[raddr_i];
    rang_o  <= ang_mem[raddr_i];
  end

endmodule

@@ rtl/kai_div.sv @@
// ----------------------------------------------------------------------------
// kai_div
// Iterative restoring divider, one quotient bit per cycle. The quotient is
// known to fit DIV_QUO_W bits, so the upper dividend bits seed the remainder.
// ----------------------------------------------------------------------------
module kai_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kai_pkg::div_req_t req_i,
  output kai_pkg::div_rsp_t rsp_o
);
  import kai_pkg::*;

  localparam int CNT_W = $clog2(DIV_QUO_W);

  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [DIV_DVS_W-1:0] rem_q, rem_d;
  logic [DIV_DVS_W-1:0] dvs_q, dvs_d;
  logic [DIV_QUO_W-1:0] quo_q, quo_d;
  logic [DIV_DVS_W:0]   trial;
  logic [DIV_DVS_W:0]   diff;
  logic                 fits;

  // One restoring step
  assign trial = {rem_q, quo_q[DIV_QUO_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = DIV_DVS_W'(req_i.dividend[DIV_DVD_W-1:DIV_QUO_W]);
      quo_d = req_i.dividend[DIV_QUO_W-1:0];
      dvs_d = req_i.divisor;
    end else if (run_q) begin
      rem_d = fits ? diff[DIV_DVS_W-1:0] : trial[DIV_DVS_W-1:0];
      quo_d = {quo_q[DIV_QUO_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIV_QUO_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath, no reset
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

@@ tb/keyframe_angle_interpolator_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyframe_angle_interpolator_top_tb
// Self-checking bench for the keyframe angle interpolator. A queue of pending
// requests feeds a clocked driver, and a clocked monitor compares every
// strobed result against answers predicted from a private copy of the key
// table and default angle. A short directed run covers the corner cases.
// Random keyframe runs follow in phases with different default angles and
// sender idle rates.
// ----------------------------------------------------------------------------
module keyframe_angle_interpolator_top_tb;
  import kai_pkg::*;

  localparam int     MAX_KEYS      = 16;
  localparam logic [1:0] FN_UNUSED = 2'd3;
  localparam longint STEP_UNIT     = longint'(STEP_ONE);
  localparam int     RANDOM_ITEMS  = 1700;
  localparam int     PHASES        = 8;
  localparam int     SETTLE_CYCLES = 45;
  localparam int     DRAIN_CYCLES  = 60;
  localparam longint TIMEOUT_NS    = 5_000_000;

  typedef struct packed {
    logic                      is_cfg;
    logic [6:0]                idle_pct;
    logic [1:0]                func;
    logic [STEP_W-1:0]         kstep;
    logic signed [ANG_W-1:0]   kang;
    logic signed [QSTEP_W-1:0] qstep;
  } keyframe_req_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] angle;
    logic [1:0]              status;
  } answer_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  logic [1:0]                func_i       = FN_CLEAR;
  logic [STEP_W-1:0]         key_step_i   = '0;
  logic signed [ANG_W-1:0]   key_angle_i  = '0;
  logic signed [QSTEP_W-1:0] query_step_i = '0;
  logic                      cfg_we_i     = 1'b0;
  logic signed [ANG_W-1:0]   cfg_wdata_i  = '0;
  logic                      strobe;
  logic signed [OUT_W-1:0]   angle_out_o;
  logic [1:0]                status_o;

  keyframe_req_t keyframe_req_q[$];
  answer_t       answer_q[$];
  keyframe_req_t cur_req;
  int            idle_pct   = 0;
  int            quiet_cnt  = 0;
  int            error_count = 0;

  // Predicted key table and default angle
  longint step_tab[MAX_KEYS];
  longint ang_tab[MAX_KEYS];
  int     key_total  = 0;
  longint dflt_angle = 0;

  keyframe_angle_interpolator_top #(
    .MAX_KEYS(MAX_KEYS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .func_i      (func_i),
    .key_step_i  (key_step_i),
    .key_angle_i (key_angle_i),
    .query_step_i(query_step_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .strobe      (strobe),
    .angle_out_o (angle_out_o),
    .status_o    (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint clip_angle(input longint a);
    if (a < ANG_MIN_I) begin
      return ANG_MIN_I;
    end else if (a > ANG_MAX_I) begin
      return ANG_MAX_I;
    end
    return a;
  endfunction

  // Interpolate along the shorter arc between the bracketing keys
  function automatic longint arc_angle_at(input longint s);
    longint sb, sa, vb, va, lo, hi, dlt, num, den, p, q;
    int     i;
    sb = 0;
    sa = STEP_UNIT;
    if (s >= STEP_UNIT) begin
      return ang_tab[key_total-1];
    end
    vb = (step_tab[0] == 0) ? ang_tab[0] : dflt_angle;
    va = ang_tab[key_total-1];
    for (i = 0; i < key_total && s >= step_tab[i]; i++) begin
      sb = step_tab[i];
      vb = ang_tab[i];
    end
    for (i = key_total - 1; i >= 0 && s < step_tab[i]; i--) begin
      sa = step_tab[i];
      va = ang_tab[i];
    end
    lo = (vb < va) ? vb : va;
    hi = (vb < va) ? va : vb;
    if (2 * (hi - lo) <= FULL_TURN) begin
      dlt = va - vb;
    end else if (vb > va) begin
      dlt = FULL_TURN + va - vb;
    end else begin
      dlt = va - vb - FULL_TURN;
    end
    num = s - sb;
    den = sa - sb;
    if (den <= 0) begin
      return vb;
    end
    p = dlt * num;
    // Round to nearest, ties away from zero
    if (p >= 0) begin
      q = (p + den / 2) / den;
    end else begin
      q = -((-p + den / 2) / den);
    end
    return vb + q;
  endfunction

  // Apply one request to the predicted table and return its answer
  function automatic answer_t apply_keyframe_op(input keyframe_req_t r);
    answer_t a;
    longint  ks, qs;
    a.angle  = '0;
    a.status = ST_OK;
    case (r.func)
      FN_CLEAR: begin
        key_total = 0;
      end
      FN_APPEND: begin
        ks = longint'(r.kstep);
        if (ks > STEP_UNIT) ks = STEP_UNIT;
        if (key_total >= MAX_KEYS) begin
          a.status = ST_FULL;
        end else if (key_total > 0 && ks < step_tab[key_total-1]) begin
          a.status = ST_ORDER;
        end else begin
          step_tab[key_total] = ks;
          ang_tab[key_total]  = clip_angle(longint'($signed(r.kang)));
          key_total++;
        end
      end
      FN_QUERY: begin
        if (key_total == 0) begin
          a.status = ST_EMPTY;
        end else begin
          qs = longint'($signed(r.qstep));
          if (qs < 0) qs = 0;
          if (qs > STEP_UNIT) qs = STEP_UNIT;
          a.angle = OUT_W'(arc_angle_at(qs));
        end
      end
      FN_UNUSED: begin
      end
      default: begin
      end
    endcase
    return a;
  endfunction

  // Driver: hold a request until taken, write the register only when idle
  always @(posedge clk_i or negedge rst_ni) begin
    logic          take;
    logic          nxt_start;
    logic          nxt_we;
    keyframe_req_t nxt;
    if (!rst_ni) begin
      start    <= 1'b0;
      cfg_we_i <= 1'b0;
    end else begin
      take      = start && !busy;
      nxt_start = start && busy;
      nxt_we    = 1'b0;
      if (take) answer_q = {answer_q, apply_keyframe_op(cur_req)};
      if (!nxt_start && keyframe_req_q.size() != 0) begin
        nxt = keyframe_req_q[0];
        if (nxt.is_cfg) begin
          // Let the block drain and settle before touching the register
          if (take || answer_q.size() != 0 || strobe || busy) begin
            quiet_cnt = 0;
          end else if (quiet_cnt < SETTLE_CYCLES) begin
            quiet_cnt++;
          end else begin
            void'(keyframe_req_q.pop_front());
            cfg_wdata_i <= nxt.kang;
            nxt_we     = 1'b1;
            idle_pct   = int'(nxt.idle_pct);
            dflt_angle = clip_angle(longint'($signed(nxt.kang)));
            quiet_cnt  = 0;
          end
        end else if ($urandom_range(99) >= idle_pct) begin
          void'(keyframe_req_q.pop_front());
          cur_req = nxt;
          func_i       <= nxt.func;
          key_step_i   <= nxt.kstep;
          key_angle_i  <= nxt.kang;
          query_step_i <= nxt.qstep;
          nxt_start = 1'b1;
        end
      end
      start    <= nxt_start;
      cfg_we_i <= nxt_we;
    end
  end

  // Monitor: compare each strobed result with the oldest answer
  always @(posedge clk_i) begin
    answer_t e;
    if (rst_ni && strobe) begin
      if (answer_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result angle %0d status %0d", $time,
                 $signed(angle_out_o), status_o);
      end else begin
        e = answer_q.pop_front();
        if (angle_out_o !== e.angle) begin
          error_count++;
          $display("%0t: angle_out expected %0d actual %0d", $time,
                   $signed(e.angle), $signed(angle_out_o));
        end
        if (status_o !== e.status) begin
          error_count++;
          $display("%0t: status expected %0d actual %0d", $time, e.status, status_o);
        end
      end
    end
  end

  task automatic queue_op(input logic [1:0] fn, input longint kstep, input longint kang,
                          input longint qstep);
    keyframe_req_t r;
    r.is_cfg   = 1'b0;
    r.idle_pct = '0;
    r.func     = fn;
    r.kstep    = STEP_W'(kstep);
    r.kang     = ANG_W'(kang);
    r.qstep    = QSTEP_W'(qstep);
    keyframe_req_q = {keyframe_req_q, r};
  endtask

  task automatic queue_setting(input longint value, input int pct);
    keyframe_req_t r;
    r          = '0;
    r.is_cfg   = 1'b1;
    r.idle_pct = 7'(pct);
    r.kang     = ANG_W'(value);
    keyframe_req_q = {keyframe_req_q, r};
  endtask

  // One keyframe run: usually a clear, ascending appends with some faults, then queries
  task automatic queue_keyframe_run(inout int budget);
    int     n_keys, n_queries, i;
    longint cur, ang, stp;
    if ($urandom_range(7) != 0) begin
      queue_op(FN_CLEAR, $urandom_range(131071), $urandom_range(131071),
               $urandom_range(262143));
      budget--;
    end
    n_keys = ($urandom_range(8) == 0) ? $urandom_range(16, 19) : $urandom_range(1, 8);
    cur    = ($urandom_range(3) == 0) ? 0 : $urandom_range(40000);
    for (i = 0; i < n_keys; i++) begin
      ang = ($urandom_range(9) == 0) ? longint'($urandom_range(131071))
                                     : longint'($urandom_range(92159)) - 46080;
      if (i > 0 && cur > 0 && $urandom_range(11) == 0) begin
        stp = cur - $urandom_range(1, 4000);
        if (stp < 0) stp = 0;
      end else begin
        if (i > 0 && $urandom_range(3) != 0) cur += $urandom_range(1, 20000);
        if (cur > 131071) cur = 131071;
        stp = cur;
      end
      queue_op(FN_APPEND, stp, ang, $urandom_range(262143));
      budget--;
    end
    n_queries = $urandom_range(1, 6);
    for (i = 0; i < n_queries; i++) begin
      stp = ($urandom_range(4) == 0) ? longint'($urandom_range(262143))
                                     : longint'($urandom_range(65536));
      queue_op(FN_QUERY, $urandom_range(131071), $urandom_range(131071), stp);
      budget--;
    end
    // Mix in a raw request now and then
    if ($urandom_range(9) == 0) begin
      queue_op(2'($urandom_range(3)), $urandom_range(131071), $urandom_range(131071),
               $urandom_range(262143));
      budget--;
    end
  endtask

  initial begin
    int budget, ph;
    longint setting;
    // Directed corner cases with the reset default angle
    queue_op(FN_QUERY, 0, 0, -131072);
    queue_op(FN_UNUSED, 131071, -1, -1);
    queue_op(FN_APPEND, 0, -65536, 0);
    queue_op(FN_QUERY, 0, 0, 0);
    queue_op(FN_APPEND, 16384, 65535, 0);
    queue_op(FN_APPEND, 8192, 0, 0);
    queue_op(FN_APPEND, 16384, -11520, 0);
    queue_op(FN_APPEND, 131071, 11520, 0);
    queue_op(FN_QUERY, 0, 0, -1);
    queue_op(FN_QUERY, 0, 0, 8192);
    queue_op(FN_QUERY, 0, 0, 16384);
    queue_op(FN_QUERY, 0, 0, 40000);
    queue_op(FN_QUERY, 0, 0, 65535);
    queue_op(FN_QUERY, 0, 0, 131071);
    queue_op(FN_APPEND, 1000, 0, 0);
    queue_op(FN_CLEAR, 0, 0, 0);
    queue_op(FN_QUERY, 0, 0, 100);
    queue_op(FN_APPEND, 30000, 40000, 0);
    queue_op(FN_QUERY, 0, 0, 0);
    queue_op(FN_QUERY, 0, 0, 15000);
    queue_op(FN_QUERY, 0, 0, 50000);
    queue_op(FN_APPEND, 30000, -46080, 0);
    queue_op(FN_QUERY, 0, 0, 30000);
    queue_op(FN_QUERY, 0, 0, 65536);

    // Random phases: new default angle and sender idle rate in each
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       setting = 46079;
        1:       setting = -46080;
        2:       setting = 65535;
        3:       setting = -65536;
        4:       setting = 0;
        default: setting = longint'($urandom_range(92159)) - 46080;
      endcase
      queue_setting(setting, (ph % 4 == 1) ? 63 : (ph % 4 == 3) ? 37 : 0);
      budget = RANDOM_ITEMS / PHASES;
      while (budget > 0) queue_keyframe_run(budget);
    end

    // Hold reset, then release it
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every request to be taken and answered, then drain
    @(negedge clk_i);
    while (keyframe_req_q.size() != 0 || start || answer_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (answer_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, answer_q.size());
    end
    if (error_count == 0 && answer_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout", $time);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
